// ----- design/assert_macros.svh -----
// Assertion helpers used by the RTL. Both are disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/scd_pkg.sv -----
`default_nettype none

package scd_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int PID_W    = 16;
    localparam int MS_W     = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int TICK_W   = 32;
    localparam int SEC_W    = 28;

    localparam logic [CFG_W-1:0] TICK_LEN_RST  = 16'd55;
    localparam logic [CFG_W-1:0] MIN_SLEEP_RST = 16'd55;

    localparam int TICKS_PER_SEC = 18;
    localparam int SUB_W = $clog2(TICKS_PER_SEC);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLEEP = 2'd1;

    // input item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SLEEP  = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    // result kinds
    localparam logic RK_WAKE  = 1'b0;
    localparam logic RK_FINAL = 1'b1;

    // status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_SHORT    = 2'd1;
    localparam logic [1:0] STS_FULL     = 2'd2;
    localparam logic [1:0] STS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [PID_W-1:0]  proc;
        logic [MS_W-1:0]   rem;
    } t_entry;

    // push: every cell takes its head-side neighbor (insert at head)
    // pop:  queue step, head leaves, processed head re-enters at the tail unless dropped
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    typedef struct packed {
        logic              start;
        logic [MS_W-1:0]   dividend;
        logic [CFG_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [MS_W-1:0]   quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FINAL = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ----- design/sleep_countdown_table.sv -----
// Channel   Direction  Handshake                   Payload
// in        to block   i_in_valid / o_in_stall     i_kind, i_proc_id, i_sleep_ms
// out       from block o_out_valid / i_out_stall   o_result_kind, o_proc_id_res, o_status,
//                                                  o_tick_count, o_uptime_sec, o_last
// cfg       to block   i_cfg_we                    i_cfg_index, i_cfg_data
//
// One item at a time. Tick and cancel walk the table as a queue through the head cell,
// one entry per cycle while no wake waits on a stalled output register.
// Sleep request: the quotient comes from the 32-step serial divider, then the entry is pushed.
// Short, full and unused kinds go straight to the final result.
// Synchronous active-low reset empties the table and clears the tick counter.
// Output stall holds a wake or the final result until the output register is free.
`default_nettype none

module sleep_countdown_table #(
    parameter int SLOTS = scd_pkg::SLOTS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [1:0]                     i_kind,
    input  wire  [scd_pkg::PID_W-1:0]      i_proc_id,
    input  wire  [scd_pkg::MS_W-1:0]       i_sleep_ms,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_result_kind,
    output logic [scd_pkg::PID_W-1:0]      o_proc_id_res,
    output logic [1:0]                     o_status,
    output logic [scd_pkg::TICK_W-1:0]     o_tick_count,
    output logic [scd_pkg::SEC_W-1:0]      o_uptime_sec,
    output logic                           o_last,
    input  wire                            i_cfg_we,
    input  wire  [scd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [scd_pkg::CFG_W-1:0]      i_cfg_data
);
    import scd_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(SLOTS + 1);

    t_state            r_state, n_state;
    logic [1:0]        r_kind, n_kind;
    logic [PID_W-1:0]  r_pid, n_pid;
    logic [1:0]        r_status, n_status;
    logic [CNT_W-1:0]  r_steps, n_steps;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_found, n_found;

    logic [CFG_W-1:0]  r_tick_len;
    logic [CFG_W-1:0]  r_min;
    logic [TICK_W-1:0] r_tick;
    logic [SUB_W-1:0]  r_sub;
    logic [SEC_W-1:0]  r_sec;

    logic              r_out_valid;
    logic              r_o_kind;
    logic [PID_W-1:0]  r_o_pid;
    logic [1:0]        r_o_status;
    logic [TICK_W-1:0] r_o_tick;
    logic [SEC_W-1:0]  r_o_sec;
    logic              r_o_last;

    t_entry            w_ent [SLOTS];
    logic [SLOTS-1:0]  w_valid;
    t_entry            w_head;
    t_entry            w_new;
    t_entry            w_empty;
    t_cell_ctl         w_ctl;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    logic              w_is_tick;
    logic [MS_W-1:0]   w_dec;
    logic              w_drop;
    logic              w_wake;
    logic              w_out_free;
    logic              w_load_wake;
    logic              w_load_final;
    logic              w_tick_adv;

    // ---------------- cell row ----------------
    assign w_empty = '0;

    for (genvar j = 0; j < SLOTS; j++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (j == 0) begin : g_first
            assign w_left = w_new;
        end else begin : g_mid
            assign w_left = w_ent[j-1];
        end
        if (j == SLOTS - 1) begin : g_last
            assign w_right = w_empty;
        end else begin : g_inner
            assign w_right = w_ent[j+1];
        end
        scd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_head),
            .o_ent   (w_ent[j])
        );
        assign w_valid[j] = w_ent[j].valid;
    end

    // ---------------- divider ----------------
    scd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------- head processing ----------------
    assign w_is_tick = (r_kind == KIND_TICK);
    assign w_dec     = w_ent[0].rem - MS_W'(1);
    assign w_drop    = w_is_tick ? (w_dec == '0)
                                 : (!r_found && (w_ent[0].proc == r_pid));
    assign w_wake    = w_is_tick && w_drop;

    assign w_head.valid = !w_drop;
    assign w_head.proc  = w_ent[0].proc;
    assign w_head.rem   = w_is_tick ? w_dec : w_ent[0].rem;

    assign w_new.valid = 1'b1;
    assign w_new.proc  = r_pid;
    assign w_new.rem   = (w_div_rsp.quotient == '0) ? MS_W'(1) : w_div_rsp.quotient;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // ---------------- control ----------------
    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_pid    = r_pid;
        n_status = r_status;
        n_steps  = r_steps;
        n_count  = r_count;
        n_found  = r_found;
        w_ctl    = '0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = i_sleep_ms;
        w_div_req.divisor  = (r_tick_len == '0) ? CFG_W'(1) : r_tick_len;
        w_load_wake  = 1'b0;
        w_load_final = 1'b0;
        w_tick_adv   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind   = i_kind;
                    n_pid    = (i_kind == KIND_TICK) ? '0 : i_proc_id;
                    n_found  = 1'b0;
                    n_steps  = r_count;
                    n_status = STS_OK;
                    case (i_kind)
                        KIND_TICK: begin
                            w_tick_adv = 1'b1;
                            n_state    = ST_SCAN;
                        end
                        KIND_SLEEP: begin
                            if (i_sleep_ms < {{(MS_W-CFG_W){1'b0}}, r_min}) begin
                                n_status = STS_SHORT;
                                n_state  = ST_FINAL;
                            end else if (w_valid[SLOTS-1]) begin
                                n_status = STS_FULL;
                                n_state  = ST_FINAL;
                            end else begin
                                w_div_req.start = 1'b1;
                                n_state         = ST_DIV;
                            end
                        end
                        KIND_CANCEL: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_FINAL;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    w_ctl.push = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                    n_state    = ST_FINAL;
                end
            end
            ST_SCAN: begin
                if (r_steps == '0) begin
                    n_status = (!w_is_tick && !r_found) ? STS_NOTFOUND : STS_OK;
                    n_state  = ST_FINAL;
                end else if (!w_wake || w_out_free) begin
                    w_ctl.pop   = 1'b1;
                    n_steps     = r_steps - CNT_W'(1);
                    w_load_wake = w_wake;
                    if (w_drop) begin
                        n_count = r_count - CNT_W'(1);
                        n_found = 1'b1;
                    end
                end
            end
            ST_FINAL: begin
                if (w_out_free) begin
                    w_load_final = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_steps <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_steps <= n_steps;
            r_found <= n_found;
        end
        r_kind   <= n_kind;
        r_pid    <= n_pid;
        r_status <= n_status;
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_len <= TICK_LEN_RST;
            r_min      <= MIN_SLEEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TICK_LEN:  r_tick_len <= i_cfg_data;
                CFG_MIN_SLEEP: r_min      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- tick counter and seconds ----------------
    // seconds kept alongside the counter so no divide by 18 is needed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_sub  <= '0;
            r_sec  <= '0;
        end else if (w_tick_adv) begin
            r_tick <= r_tick + TICK_W'(1);
            if (r_tick == '1) begin
                r_sub <= '0;
                r_sec <= '0;
            end else if (r_sub == SUB_W'(TICKS_PER_SEC - 1)) begin
                r_sub <= '0;
                r_sec <= r_sec + SEC_W'(1);
            end else begin
                r_sub <= r_sub + SUB_W'(1);
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_wake || w_load_final) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_load_wake) begin
            r_o_kind   <= RK_WAKE;
            r_o_pid    <= w_ent[0].proc;
            r_o_status <= STS_OK;
            r_o_last   <= 1'b0;
        end else if (w_load_final) begin
            r_o_kind   <= RK_FINAL;
            r_o_pid    <= r_pid;
            r_o_status <= r_status;
            r_o_last   <= 1'b1;
        end
        if (w_load_wake || w_load_final) begin
            r_o_tick <= r_tick;
            r_o_sec  <= r_sec;
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_o_kind;
    assign o_proc_id_res     = r_o_pid;
    assign o_status          = r_o_status;
    assign o_tick_count      = r_o_tick;
    assign o_uptime_sec      = r_o_sec;
    assign o_last            = r_o_last;

    // ---------------- assertions ----------------
    `SCD_ASSERT_IMP(a_count_matches, 1'b1, ($countones(w_valid) == int'(r_count)),
        "occupied count disagrees with cell valid bits")
    `SCD_ASSERT_IMP(a_head_occupied, 1'b1, (w_valid[0] == (r_count != '0)),
        "occupied run does not start at the head cell")
    `SCD_ASSERT_IMP(a_div_done_state, w_div_rsp.done, (r_state == ST_DIV),
        "divider finished outside the divide state")
    `SCD_ASSERT_NXT(a_wake_in_scan, (w_load_wake), (o_out_valid && !o_last),
        "wake result not presented after load")
    `SCD_ASSERT_IMP(a_steps_bound, (r_state == ST_SCAN), (r_steps <= r_count || !w_is_tick
        || r_steps <= CNT_W'(SLOTS)), "walk step count out of range")

endmodule

`default_nettype wire

// ----- design/scd_cell.sv -----
`default_nettype none

module scd_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire scd_pkg::t_cell_ctl  i_ctl,
    input  wire scd_pkg::t_entry     i_left,
    input  wire scd_pkg::t_entry     i_right,
    input  wire scd_pkg::t_entry     i_head,
    output scd_pkg::t_entry     o_ent
);
    import scd_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.push) begin
            n_ent = i_left;
        end else if (i_ctl.pop) begin
            if (i_right.valid) begin
                n_ent = i_right;
            end else if (r_ent.valid) begin
                // this cell is the tail of the occupied run
                n_ent = i_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.proc <= n_ent.proc;
        r_ent.rem  <= n_ent.rem;
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

// ----- design/scd_divider.sv -----
`default_nettype none

module scd_divider (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire scd_pkg::t_div_req   i_req,
    output scd_pkg::t_div_rsp   o_rsp
);
    import scd_pkg::*;

    localparam int CNT_W = $clog2(MS_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [CFG_W-1:0]  r_rem;
    logic [MS_W-1:0]   r_quo;
    logic [CFG_W-1:0]  r_dvs;

    logic [CFG_W:0]    w_trial;
    logic [CFG_W:0]    w_diff;
    logic              w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[MS_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[CFG_W-1:0] : w_trial[CFG_W-1:0];
            r_quo <= {r_quo[MS_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire
